@@ rtl/psp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_pkg
// Types and constants shared by the polyphonic sample player.
// ----------------------------------------------------------------------------
package psp_pkg;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_TRIGGER = 2'd1;
  localparam logic [1:0] KIND_LOAD    = 2'd2;

  localparam logic [1:0] CFG_AMPLITUDE   = 2'd0;
  localparam logic [1:0] CFG_LOOP_ENABLE = 2'd1;
  localparam logic [1:0] CFG_SOURCE_CH   = 2'd2;

  localparam int          DIV_STEPS     = 17;
  localparam logic [16:0] GAIN_UNITY    = 17'h10000;
  localparam logic [15:0] AMP_RESET     = 16'd16384;

  typedef struct packed {
    logic [1:0]         kind;
    logic [15:0]        begin_pos;
    logic [15:0]        end_pos;
    logic [23:0]        step_rate;
    logic [15:0]        attack_len;
    logic               load_channel;
    logic [15:0]        load_addr;
    logic signed [15:0] load_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_ch0;
    logic signed [31:0] out_ch1;
  } out_item_t;

  typedef struct packed {
    logic [31:0] position;
    logic [15:0] begin_pos;
    logic [15:0] end_pos;
    logic [23:0] rate;
    logic [16:0] gain;
    logic [16:0] gain_step;
    logic [15:0] attack_len;
    logic [15:0] out_count;
  } voice_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_VSEL,
    ST_VMEM,
    ST_VMUL,
    ST_VACC,
    ST_OUT,
    ST_DIV,
    ST_TRIG,
    ST_LOAD
  } state_e;

  typedef struct packed {
    logic capture;
    logic acc_clr;
    logic vrd;
    logic mem_rd;
    logic mul;
    logic acc_en;
    logic v_next;
    logic div_start;
    logic div_step;
    logic trig_wr;
    logic load_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       cur_active;
    logic       cur_last;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/psp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_if
// Handshake channels of the polyphonic sample player.
// ----------------------------------------------------------------------------
interface psp_in_if;
  logic               valid;
  logic               ready;
  psp_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psp_out_if;
  logic               valid;
  logic               ready;
  psp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface psp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/psp_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_ctrl
// Sequencer that walks ticks over the voices, triggers and loads.
// ----------------------------------------------------------------------------
module psp_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_ready_o,
  input  wire psp_pkg::sts_t sts_i,
  output psp_pkg::cmd_t     cmd_o
);
  import psp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (sts_i.kind)
          KIND_TICK:    state_d = ST_VSEL;
          KIND_TRIGGER: state_d = ST_DIV;
          KIND_LOAD:    state_d = ST_LOAD;
          default:      state_d = ST_IDLE;
        endcase
      end
      ST_VSEL: begin
        if (sts_i.cur_active) state_d = ST_VMEM;
        else if (sts_i.cur_last) state_d = ST_OUT;
      end
      ST_VMEM: state_d = ST_VMUL;
      ST_VMUL: state_d = ST_VACC;
      ST_VACC: state_d = sts_i.cur_last ? ST_OUT : ST_VSEL;
      ST_OUT: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      ST_DIV: begin
        if (sts_i.div_done) state_d = ST_TRIG;
      end
      ST_TRIG: state_d = ST_IDLE;
      ST_LOAD: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DISPATCH: begin
        cmd_o.acc_clr   = 1'b1;
        cmd_o.div_start = (sts_i.kind == KIND_TRIGGER);
      end
      ST_VSEL: begin
        cmd_o.vrd    = sts_i.cur_active;
        cmd_o.v_next = !sts_i.cur_active && !sts_i.cur_last;
      end
      ST_VMEM: cmd_o.mem_rd = 1'b1;
      ST_VMUL: cmd_o.mul = 1'b1;
      ST_VACC: begin
        cmd_o.acc_en = 1'b1;
        cmd_o.v_next = !sts_i.cur_last;
      end
      ST_OUT:  cmd_o.out_load = sts_i.out_free;
      ST_DIV:  cmd_o.div_step = !sts_i.div_done;
      ST_TRIG: cmd_o.trig_wr = 1'b1;
      ST_LOAD: cmd_o.load_wr = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/psp_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// psp_datapath
// Voice store, sample memories, gain divider, mixer and output register.
// ----------------------------------------------------------------------------
module psp_datapath #(
  parameter int VOICES       = 8,
  parameter int OUT_CHANNELS = 2,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire psp_pkg::in_item_t  in_data_i,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  output psp_pkg::out_item_t      out_data_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  input  wire psp_pkg::cmd_t      cmd_i,
  output psp_pkg::sts_t           sts_o
);
  import psp_pkg::*;

  localparam int VW    = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW    = $clog2(SAMPLE_DEPTH);
  localparam int ACC_W = 35 + $clog2(VOICES);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-64'sd2147483648);

  // Configuration registers.
  logic [15:0] amp_q;
  logic        loop_q;
  logic [1:0]  srcch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q   <= AMP_RESET;
      loop_q  <= 1'b0;
      srcch_q <= 2'd1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_AMPLITUDE:   amp_q   <= cfg_data_i;
        CFG_LOOP_ENABLE: loop_q  <= cfg_data_i[0];
        CFG_SOURCE_CH:   srcch_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  logic src_two;
  assign src_two = srcch_q[1];

  in_item_t item_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) item_q <= in_data_i;
  end

  // Voice control state.
  logic [VOICES-1:0] active_q;
  logic [VW-1:0]     vc_q, nv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
      nv_q <= '0;
    end else begin
      if (cmd_i.acc_clr) vc_q <= '0;
      else if (cmd_i.v_next) vc_q <= vc_q + VW'(1);
      if (cmd_i.trig_wr) nv_q <= (nv_q == VW'(VOICES - 1)) ? '0 : nv_q + VW'(1);
    end
  end

  // Gain step divider: 65536 / attack length, one quotient bit per cycle.
  logic [15:0] len;
  logic [16:0] dvd_q, quo_q, rem_q, div_trial;
  logic [4:0]  dcnt_q;
  logic        div_ge;

  assign len       = (item_q.attack_len == 16'd0) ? 16'd1 : item_q.attack_len;
  assign div_trial = {rem_q[15:0], dvd_q[16]};
  assign div_ge    = div_trial >= {1'b0, len};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_start) begin
      dcnt_q <= 5'(DIV_STEPS);
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q - 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= GAIN_UNITY;
      rem_q <= '0;
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      dvd_q <= {dvd_q[15:0], 1'b0};
      rem_q <= div_ge ? (div_trial - {1'b0, len}) : div_trial;
      quo_q <= {quo_q[15:0], div_ge};
    end
  end

  // Voice store.
  voice_t voice_mem [VOICES];
  voice_t rec_q, rec_upd, rec_new;
  logic   upd_active;

  always_comb begin
    rec_new            = '0;
    rec_new.position   = {item_q.begin_pos, 16'h0000};
    rec_new.begin_pos  = item_q.begin_pos;
    rec_new.end_pos    = item_q.end_pos;
    rec_new.rate       = item_q.step_rate;
    rec_new.gain       = '0;
    rec_new.gain_step  = quo_q;
    rec_new.attack_len = len;
    rec_new.out_count  = '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.trig_wr) voice_mem[nv_q] <= rec_new;
    else if (cmd_i.acc_en) voice_mem[vc_q] <= rec_upd;
    if (cmd_i.vrd) rec_q <= voice_mem[vc_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.trig_wr) begin
      active_q[nv_q] <= 1'b1;
    end else if (cmd_i.acc_en) begin
      active_q[vc_q] <= upd_active;
    end
  end

  // Position and envelope update.
  logic [32:0]        pos_sum, end_fix;
  logic signed [16:0] span;
  logic signed [34:0] pos_w;
  logic               past_end;
  logic [16:0]        cnt;

  always_comb begin
    rec_upd    = rec_q;
    pos_sum    = {1'b0, rec_q.position} + {9'b0, rec_q.rate};
    end_fix    = {1'b0, rec_q.end_pos, 16'h0000};
    past_end   = pos_sum > end_fix;
    span       = $signed({1'b0, rec_q.end_pos}) - $signed({1'b0, rec_q.begin_pos});
    pos_w      = $signed({2'b00, pos_sum});
    if (past_end && loop_q) pos_w = pos_w - 35'($signed({span, 16'h0000}));
    upd_active = !(past_end && !loop_q);
    if (pos_w < 0) rec_upd.position = '0;
    else if (pos_w[34:32] != 3'b000) rec_upd.position = 32'hFFFF_FFFF;
    else rec_upd.position = pos_w[31:0];
    cnt = {1'b0, rec_q.out_count} + 17'd1;
    if (cnt <= {1'b0, rec_q.attack_len}) begin
      if (cnt == {1'b0, rec_q.attack_len}) rec_upd.gain = GAIN_UNITY;
      else rec_upd.gain = rec_q.gain + rec_q.gain_step;
    end
    rec_upd.out_count = cnt[16] ? 16'hFFFF : cnt[15:0];
  end

  // Sample memories, one per source channel.
  logic signed [15:0] smem0 [SAMPLE_DEPTH];
  logic signed [15:0] smem1 [SAMPLE_DEPTH];
  logic signed [15:0] rd0_q, rd1_q;
  logic               oob_q;
  logic [15:0]        idx;
  logic               load_ok;

  assign idx     = rec_q.position[31:16];
  assign load_ok = {1'b0, item_q.load_addr} < 17'(SAMPLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && load_ok && !item_q.load_channel)
      smem0[item_q.load_addr[AW-1:0]] <= item_q.load_value;
    if (cmd_i.mem_rd) rd0_q <= smem0[idx[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr && load_ok && item_q.load_channel)
      smem1[item_q.load_addr[AW-1:0]] <= item_q.load_value;
    if (cmd_i.mem_rd) rd1_q <= smem1[idx[AW-1:0]];
  end

  // Gain and mixing.
  logic [32:0]        ag_full;
  logic [16:0]        ag_q;
  logic signed [15:0] s0, s1;
  logic signed [33:0] prod0_q, prod1_q;
  logic signed [ACC_W-1:0] acc0_q, acc1_q;

  assign ag_full = {17'b0, amp_q} * {16'b0, rec_q.gain};
  assign s0 = oob_q ? 16'sd0 : rd0_q;
  assign s1 = oob_q ? 16'sd0 : (src_two ? rd1_q : rd0_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_rd) begin
      ag_q  <= ag_full[32:16];
      oob_q <= {1'b0, idx} >= 17'(SAMPLE_DEPTH);
    end
    if (cmd_i.mul) begin
      prod0_q <= s0 * $signed({1'b0, ag_q});
      prod1_q <= s1 * $signed({1'b0, ag_q});
    end
    if (cmd_i.acc_clr) begin
      acc0_q <= '0;
      acc1_q <= '0;
    end else if (cmd_i.acc_en) begin
      acc0_q <= acc0_q + ACC_W'(prod0_q);
      acc1_q <= acc1_q + ACC_W'(prod1_q);
    end
  end

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] a);
    logic signed [31:0] r;
    if (a > SAT_MAX) r = 32'sh7FFF_FFFF;
    else if (a < SAT_MIN) r = 32'sh8000_0000;
    else r = a[31:0];
    return r;
  endfunction

  // Output register.
  logic      out_valid_q;
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.out_ch0 <= sat32(acc0_q);
      out_q.out_ch1 <= (OUT_CHANNELS > 1) ? sat32(acc1_q) : 32'sd0;
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

  assign sts_o.kind       = item_q.kind;
  assign sts_o.cur_active = active_q[vc_q];
  assign sts_o.cur_last   = (vc_q == VW'(VOICES - 1));
  assign sts_o.div_done   = (dcnt_q == 5'd0);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  a_div_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |=> dcnt_q == 5'(DIV_STEPS))
    else $error("divider count not loaded");
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output word overwritten");
  a_step_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.trig_wr |-> quo_q != 17'd0)
    else $error("gain step is zero");

endmodule
`default_nettype wire

@@ rtl/polyphonic_sample_player.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyphonic_sample_player
// Multi-voice playback of a stored sample with attack ramps and mixing.
// ----------------------------------------------------------------------------
// Items are handled one at a time. A load word passes through dispatch and
// the memory write; a trigger passes through dispatch, the bit-serial
// divider that forms the gain step and the voice store write; a tick walks
// the voices one by one, taking each active voice through a voice store
// read, a sample memory read, a gain multiply and an accumulate, and then
// waits for the output register to be free. The input is taken again while
// a finished frame still waits in the output register. The sample memory
// needs no clearing; entries are defined once loaded.
// ----------------------------------------------------------------------------
module polyphonic_sample_player #(
  parameter int VOICES       = 8,
  parameter int OUT_CHANNELS = 2,
  parameter int SAMPLE_DEPTH = 65536
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  psp_in_if.sink    in_i,
  psp_out_if.source out_o,
  psp_cfg_if.sink   cfg_i
);
  import psp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Configuration is always taken; the user must change it only while the block is idle, the block does not enforce it.
  assign cfg_i.ready = 1'b1;

  psp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  psp_datapath #(
    .VOICES       (VOICES),
    .OUT_CHANNELS (OUT_CHANNELS),
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_i.data),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_data_o  (out_o.data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire
